FILE: sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned UsW    = 24;
  localparam int unsigned CmW    = 16;
  localparam int unsigned PreW   = 8;
  localparam int unsigned TrigW  = 10;
  localparam int unsigned CfgAW  = 3;
  localparam int unsigned CfgDW  = 24;

  localparam logic [UsW-1:0] UsMax = {UsW{1'b1}};
  localparam logic [CmW-1:0] CmMax = {CmW{1'b1}};

  localparam logic [PreW-1:0]  RstTicksPerUs   = 8'd1;
  localparam logic [TrigW-1:0] RstTriggerLowUs = 10'd30;
  localparam logic [TrigW-1:0] RstTriggerHiUs  = 10'd10;
  localparam logic [PreW-1:0]  RstCmDivisorUs  = 8'd58;
  localparam logic [CmW-1:0]   RstRangeLimitCm = 16'd20;
  localparam logic [UsW-1:0]   RstPauseUs      = 24'd100000;

  typedef enum logic [CfgAW-1:0] {
    REG_TICKS_PER_US    = 3'd0,
    REG_TRIGGER_LOW_US  = 3'd1,
    REG_TRIGGER_HIGH_US = 3'd2,
    REG_CM_DIVISOR_US   = 3'd3,
    REG_RANGE_LIMIT_CM  = 3'd4,
    REG_PAUSE_US        = 3'd5
  } uer_reg_t;

  typedef struct packed {
    logic [PreW-1:0]  ticks_per_us;
    logic [TrigW-1:0] trigger_low_us;
    logic [TrigW-1:0] trigger_high_us;
    logic [PreW-1:0]  cm_divisor_us;
    logic [CmW-1:0]   range_limit_cm;
    logic [UsW-1:0]   pause_us;
  } uer_cfg_t;

  typedef struct packed {
    logic           trigger;
    logic           led;
    logic           measure_done;
    logic [UsW-1:0] echo_us;
    logic [CmW-1:0] distance_cm;
    logic           out_of_range;
  } uer_res_t;

endpackage

FILE: sv/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Time-of-flight ranging sequencer with a valid/stall beat interface.
// ----------------------------------------------------------------------------
// Each input beat is one sampled tick of the echo pin and yields exactly one
// result beat. A beat is taken every clock cycle while in_stall is low; its
// result goes to the output register, or while the result side stalls to the
// skid register of the two-entry buffer, so input can go on for one beat.
// Registers take effect on the next accepted beat.
module ultrasonic_echo_ranger (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [uer_pkg::CfgAW-1:0]  cfg_addr,
  input  logic [uer_pkg::CfgDW-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_echo,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_trigger,
  output logic                       out_led,
  output logic                       out_measure_done,
  output logic [uer_pkg::UsW-1:0]    out_echo_us,
  output logic [uer_pkg::CmW-1:0]    out_distance_cm,
  output logic                       out_out_of_range
);

  uer_pkg::uer_cfg_t cfg_r;
  uer_pkg::uer_res_t res, out_res;
  logic              in_fire, buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us    <= uer_pkg::RstTicksPerUs;
      cfg_r.trigger_low_us  <= uer_pkg::RstTriggerLowUs;
      cfg_r.trigger_high_us <= uer_pkg::RstTriggerHiUs;
      cfg_r.cm_divisor_us   <= uer_pkg::RstCmDivisorUs;
      cfg_r.range_limit_cm  <= uer_pkg::RstRangeLimitCm;
      cfg_r.pause_us        <= uer_pkg::RstPauseUs;
    end else if (cfg_we) begin
      case (cfg_addr)
        uer_pkg::REG_TICKS_PER_US:    cfg_r.ticks_per_us    <= cfg_wdata[7:0];
        uer_pkg::REG_TRIGGER_LOW_US:  cfg_r.trigger_low_us  <= cfg_wdata[9:0];
        uer_pkg::REG_TRIGGER_HIGH_US: cfg_r.trigger_high_us <= cfg_wdata[9:0];
        uer_pkg::REG_CM_DIVISOR_US:   cfg_r.cm_divisor_us   <= cfg_wdata[7:0];
        uer_pkg::REG_RANGE_LIMIT_CM:  cfg_r.range_limit_cm  <= cfg_wdata[15:0];
        uer_pkg::REG_PAUSE_US:        cfg_r.pause_us        <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  uer_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .in_echo (in_echo),
    .res     (res)
  );

  uer_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_trigger      = out_res.trigger;
  assign out_led          = out_res.led;
  assign out_measure_done = out_res.measure_done;
  assign out_echo_us      = out_res.echo_us;
  assign out_distance_cm  = out_res.distance_cm;
  assign out_out_of_range = out_res.out_of_range;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(in_valid && !in_stall)) |-> out_valid)
    else $error("accepted beat produced no result");

  a_done_no_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_measure_done) |-> !out_trigger)
    else $error("measurement completed during trigger pulse");

  a_done_led_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_measure_done) |-> (out_led != out_out_of_range))
    else $error("led and range flag disagree");

endmodule

FILE: sv/uer_fsm.sv
// ----------------------------------------------------------------------------
// uer_fsm
// Ranging sequencer: trigger timing, echo width and distance counting.
// One input beat advances the state by one clock tick of the sensor.
// ----------------------------------------------------------------------------
module uer_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  uer_pkg::uer_cfg_t   cfg,
  input  logic                in_fire,
  input  logic                in_echo,
  output uer_pkg::uer_res_t   res
);

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_PAUSE     = 3'd4
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [uer_pkg::PreW-1:0]      pre_r, pre_nxt;
  logic [uer_pkg::UsW-1:0]       cnt_r, cnt_nxt;
  logic [uer_pkg::UsW-1:0]       width_r, width_nxt;
  logic [uer_pkg::PreW-1:0]      rem_r, rem_nxt;
  logic [uer_pkg::CmW-1:0]       cm_r, cm_nxt;
  logic                          led_r, led_nxt;
  logic                          flag_r, flag_nxt;
  logic [uer_pkg::UsW-1:0]       last_w_r, last_w_nxt;
  logic [uer_pkg::CmW-1:0]       last_cm_r, last_cm_nxt;

  logic [uer_pkg::PreW-1:0]      eff_tpu, eff_div;
  logic [uer_pkg::PreW-1:0]      t_pre_inc, e_pre_base, e_pre_inc;
  logic                          t_el, e_el;
  logic [uer_pkg::UsW-1:0]       t_cnt, t_len;
  logic                          t_done;
  logic [uer_pkg::UsW-1:0]       e_w_base, e_w;
  logic [uer_pkg::PreW-1:0]      e_rem_base, e_rem_inc, e_rem;
  logic [uer_pkg::CmW-1:0]       e_cm_base, e_cm;
  logic [uer_pkg::PreW-1:0]      e_pre;
  logic                          trig, done;

  always_comb begin
    eff_tpu = (cfg.ticks_per_us == '0) ? uer_pkg::PreW'(1) : cfg.ticks_per_us;
    eff_div = (cfg.cm_divisor_us == '0) ? uer_pkg::PreW'(1) : cfg.cm_divisor_us;

    // timed phases
    t_pre_inc = pre_r + uer_pkg::PreW'(1);
    t_el      = (t_pre_inc >= eff_tpu) || (t_pre_inc == '0);
    t_cnt     = (t_el && cnt_r != uer_pkg::UsMax) ? cnt_r + uer_pkg::UsW'(1) : cnt_r;
    case (phase_r)
      PH_TRIG_LOW:  t_len = uer_pkg::UsW'(cfg.trigger_low_us);
      PH_TRIG_HIGH: t_len = uer_pkg::UsW'(cfg.trigger_high_us);
      default:      t_len = cfg.pause_us;
    endcase
    t_done = (t_cnt >= t_len);

    // echo tick, starting from cleared counters on the rising edge
    e_pre_base = (phase_r == PH_MEASURE) ? pre_r   : '0;
    e_w_base   = (phase_r == PH_MEASURE) ? width_r : '0;
    e_rem_base = (phase_r == PH_MEASURE) ? rem_r   : '0;
    e_cm_base  = (phase_r == PH_MEASURE) ? cm_r    : '0;
    e_pre_inc  = e_pre_base + uer_pkg::PreW'(1);
    e_el       = (e_pre_inc >= eff_tpu) || (e_pre_inc == '0);
    e_pre      = e_el ? '0 : e_pre_inc;
    e_w        = e_w_base;
    e_rem      = e_rem_base;
    e_cm       = e_cm_base;
    e_rem_inc  = e_rem_base + uer_pkg::PreW'(1);
    if (e_el && e_w_base != uer_pkg::UsMax) begin
      e_w = e_w_base + uer_pkg::UsW'(1);
      if (e_rem_inc >= eff_div || e_rem_inc == '0) begin
        e_rem = '0;
        if (e_cm_base != uer_pkg::CmMax) begin
          e_cm = e_cm_base + uer_pkg::CmW'(1);
        end
      end else begin
        e_rem = e_rem_inc;
      end
    end

    phase_nxt   = phase_r;
    pre_nxt     = pre_r;
    cnt_nxt     = cnt_r;
    width_nxt   = width_r;
    rem_nxt     = rem_r;
    cm_nxt      = cm_r;
    led_nxt     = led_r;
    flag_nxt    = flag_r;
    last_w_nxt  = last_w_r;
    last_cm_nxt = last_cm_r;
    trig        = 1'b0;
    done        = 1'b0;

    case (phase_r)
      PH_TRIG_LOW, PH_TRIG_HIGH, PH_PAUSE: begin
        trig = (phase_r == PH_TRIG_HIGH);
        if (t_done) begin
          pre_nxt = '0;
          cnt_nxt = '0;
          case (phase_r)
            PH_TRIG_LOW:  phase_nxt = PH_TRIG_HIGH;
            PH_TRIG_HIGH: phase_nxt = PH_WAIT_RISE;
            default:      phase_nxt = PH_TRIG_LOW;
          endcase
        end else begin
          pre_nxt = t_el ? '0 : t_pre_inc;
          cnt_nxt = t_cnt;
        end
      end
      PH_WAIT_RISE, PH_MEASURE: begin
        if (in_echo) begin
          phase_nxt = PH_MEASURE;
          pre_nxt   = e_pre;
          width_nxt = e_w;
          rem_nxt   = e_rem;
          cm_nxt    = e_cm;
          if (phase_r == PH_WAIT_RISE) begin
            cnt_nxt = '0;
          end
        end else if (phase_r == PH_MEASURE) begin
          last_w_nxt  = width_r;
          last_cm_nxt = cm_r;
          flag_nxt    = (cm_r >= cfg.range_limit_cm);
          led_nxt     = (cm_r < cfg.range_limit_cm);
          done        = 1'b1;
          phase_nxt   = PH_PAUSE;
          pre_nxt     = '0;
          cnt_nxt     = '0;
        end
      end
      default: begin
        phase_nxt = PH_TRIG_LOW;
        pre_nxt   = '0;
        cnt_nxt   = '0;
      end
    endcase

    res.trigger      = trig;
    res.led          = led_nxt;
    res.measure_done = done;
    res.echo_us      = last_w_nxt;
    res.distance_cm  = last_cm_nxt;
    res.out_of_range = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TRIG_LOW;
      pre_r     <= '0;
      cnt_r     <= '0;
      width_r   <= '0;
      rem_r     <= '0;
      cm_r      <= '0;
      led_r     <= 1'b0;
      flag_r    <= 1'b0;
      last_w_r  <= '0;
      last_cm_r <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      pre_r     <= pre_nxt;
      cnt_r     <= cnt_nxt;
      width_r   <= width_nxt;
      rem_r     <= rem_nxt;
      cm_r      <= cm_nxt;
      led_r     <= led_nxt;
      flag_r    <= flag_nxt;
      last_w_r  <= last_w_nxt;
      last_cm_r <= last_cm_nxt;
    end
  end

endmodule

FILE: sv/uer_skid.sv
// ----------------------------------------------------------------------------
// uer_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module uer_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  uer_pkg::uer_res_t   push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output uer_pkg::uer_res_t   out_data
);

  logic              out_valid_r, sk_valid_r;
  uer_pkg::uer_res_t out_data_r, sk_data_r;
  logic              pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = sk_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= sk_valid_r ? sk_data_r : push_data;
    end
    if (push && out_valid_r && !pop) begin
      sk_data_r <= push_data;
    end
  end

endmodule

FILE: tb/ranger_checker.sv
// ----------------------------------------------------------------------------
// ranger_checker
// Watches the echo and result channels of the ultrasonic echo ranger, runs a
// cycle-accurate prediction of the ranging sequencer for every accepted echo
// beat and compares each accepted result beat field by field, in order.
// ----------------------------------------------------------------------------
module ranger_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [uer_pkg::CfgAW-1:0] cfg_addr,
  input  logic [uer_pkg::CfgDW-1:0] cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_echo,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_trigger,
  input  logic                      out_led,
  input  logic                      out_measure_done,
  input  logic [uer_pkg::UsW-1:0]   out_echo_us,
  input  logic [uer_pkg::CmW-1:0]   out_distance_cm,
  input  logic                      out_out_of_range,
  output int                        mismatches,
  output int                        outstanding,
  output int                        measurements
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SEQ_TRIG_LOW,
    SEQ_TRIG_HIGH,
    SEQ_WAIT_RISE,
    SEQ_MEASURE,
    SEQ_PAUSE
  } seq_phase_t;

  uer_pkg::uer_cfg_t        regs;
  seq_phase_t               seq;
  logic [uer_pkg::PreW-1:0] prescale;
  logic [uer_pkg::PreW-1:0] cm_rem;
  logic [uer_pkg::UsW-1:0]  phase_us;
  logic [uer_pkg::UsW-1:0]  width_us;
  logic [uer_pkg::UsW-1:0]  last_width;
  logic [uer_pkg::CmW-1:0]  cm_cnt;
  logic [uer_pkg::CmW-1:0]  last_cm;
  logic                     led_q;
  logic                     far_q;
  uer_pkg::uer_res_t        readings_q[$];

  function automatic void enter_phase(seq_phase_t p);
    seq      = p;
    prescale = '0;
    phase_us = '0;
  endfunction

  function automatic void reset_ranger();
    regs.ticks_per_us    = uer_pkg::RstTicksPerUs;
    regs.trigger_low_us  = uer_pkg::RstTriggerLowUs;
    regs.trigger_high_us = uer_pkg::RstTriggerHiUs;
    regs.cm_divisor_us   = uer_pkg::RstCmDivisorUs;
    regs.range_limit_cm  = uer_pkg::RstRangeLimitCm;
    regs.pause_us        = uer_pkg::RstPauseUs;
    enter_phase(SEQ_TRIG_LOW);
    width_us   = '0;
    cm_rem     = '0;
    cm_cnt     = '0;
    led_q      = 1'b0;
    far_q      = 1'b0;
    last_width = '0;
    last_cm    = '0;
  endfunction

  // one clock tick of the microsecond prescaler; zero ticks_per_us acts as 1
  function automatic logic us_strobe();
    logic [uer_pkg::PreW-1:0] ticks;
    ticks = (regs.ticks_per_us == '0) ? uer_pkg::PreW'(1) : regs.ticks_per_us;
    prescale = prescale + 1'b1;
    if (prescale >= ticks || prescale == '0) begin
      prescale = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void count_width();
    logic [uer_pkg::PreW-1:0] div;
    logic                     us;
    div = (regs.cm_divisor_us == '0) ? uer_pkg::PreW'(1) : regs.cm_divisor_us;
    us  = us_strobe();
    if (us && width_us != uer_pkg::UsMax) begin
      width_us = width_us + 1'b1;
      cm_rem   = cm_rem + 1'b1;
      if (cm_rem >= div || cm_rem == '0) begin
        cm_rem = '0;
        if (cm_cnt != uer_pkg::CmMax) cm_cnt = cm_cnt + 1'b1;
      end
    end
  endfunction

  // timed phase tick; a zero length still lasts one tick
  function automatic logic phase_over(logic [uer_pkg::UsW-1:0] len);
    logic us;
    us = us_strobe();
    if (us && phase_us != uer_pkg::UsMax) phase_us = phase_us + 1'b1;
    return phase_us >= len;
  endfunction

  function automatic uer_pkg::uer_res_t advance_ranger(logic echo);
    uer_pkg::uer_res_t r;
    r = '0;
    case (seq)
      SEQ_TRIG_LOW: begin
        if (phase_over(uer_pkg::UsW'(regs.trigger_low_us))) enter_phase(SEQ_TRIG_HIGH);
      end
      SEQ_TRIG_HIGH: begin
        r.trigger = 1'b1;
        if (phase_over(uer_pkg::UsW'(regs.trigger_high_us))) enter_phase(SEQ_WAIT_RISE);
      end
      SEQ_WAIT_RISE: begin
        if (echo) begin
          enter_phase(SEQ_MEASURE);
          width_us = '0;
          cm_rem   = '0;
          cm_cnt   = '0;
          count_width();
        end
      end
      SEQ_MEASURE: begin
        if (echo) begin
          count_width();
        end else begin
          last_width     = width_us;
          last_cm        = cm_cnt;
          far_q          = (cm_cnt >= regs.range_limit_cm);
          led_q          = ~far_q;
          r.measure_done = 1'b1;
          enter_phase(SEQ_PAUSE);
        end
      end
      SEQ_PAUSE: begin
        if (phase_over(regs.pause_us)) enter_phase(SEQ_TRIG_LOW);
      end
      default: enter_phase(SEQ_TRIG_LOW);
    endcase
    r.led          = led_q;
    r.echo_us      = last_width;
    r.distance_cm  = last_cm;
    r.out_of_range = far_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [uer_pkg::UsW-1:0] want,
                                      logic [uer_pkg::UsW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    uer_pkg::uer_res_t want;
    if (!rst_n) begin
      reset_ranger();
      readings_q.delete();
      mismatches   = 0;
      measurements = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          uer_pkg::REG_TICKS_PER_US:
            regs.ticks_per_us    = cfg_wdata[uer_pkg::PreW-1:0];
          uer_pkg::REG_TRIGGER_LOW_US:
            regs.trigger_low_us  = cfg_wdata[uer_pkg::TrigW-1:0];
          uer_pkg::REG_TRIGGER_HIGH_US:
            regs.trigger_high_us = cfg_wdata[uer_pkg::TrigW-1:0];
          uer_pkg::REG_CM_DIVISOR_US:
            regs.cm_divisor_us   = cfg_wdata[uer_pkg::PreW-1:0];
          uer_pkg::REG_RANGE_LIMIT_CM:
            regs.range_limit_cm  = cfg_wdata[uer_pkg::CmW-1:0];
          uer_pkg::REG_PAUSE_US:
            regs.pause_us        = cfg_wdata[uer_pkg::UsW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (readings_q.size() == 0) begin
          $display("%0t ns: result beat with no reading expected", $time);
          mismatches++;
        end else begin
          want = readings_q.pop_front();
          check_field("trigger", uer_pkg::UsW'(want.trigger),
                      uer_pkg::UsW'(out_trigger));
          check_field("led", uer_pkg::UsW'(want.led), uer_pkg::UsW'(out_led));
          check_field("measure_done", uer_pkg::UsW'(want.measure_done),
                      uer_pkg::UsW'(out_measure_done));
          check_field("echo_us", want.echo_us, out_echo_us);
          check_field("distance_cm", uer_pkg::UsW'(want.distance_cm),
                      uer_pkg::UsW'(out_distance_cm));
          check_field("out_of_range", uer_pkg::UsW'(want.out_of_range),
                      uer_pkg::UsW'(out_out_of_range));
          if (want.measure_done) measurements++;
        end
      end
      if (in_valid && !in_stall) readings_q.push_back(advance_ranger(in_echo));
    end
    outstanding <= readings_q.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives echo beats and register settings into the ultrasonic echo ranger
// under random source gaps and sink stalls; ranger_checker predicts and
// compares every result beat. Covers short directed pulses, random pulse
// trains over many settings, full-scale registers and the slowest prescaler.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_PAD     = 4;
  localparam int HOLD_CYCLES   = 48;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS   = 20;
  localparam logic [uer_pkg::CfgAW-1:0] REG_BEYOND =
    uer_pkg::CfgAW'(uer_pkg::REG_PAUSE_US) + 1'b1;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [uer_pkg::CfgAW-1:0] cfg_addr  = '0;
  logic [uer_pkg::CfgDW-1:0] cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_echo   = 1'b0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic                      out_trigger;
  logic                      out_led;
  logic                      out_measure_done;
  logic [uer_pkg::UsW-1:0]   out_echo_us;
  logic [uer_pkg::CmW-1:0]   out_distance_cm;
  logic                      out_out_of_range;

  int mismatches;
  int outstanding;
  int measurements;
  int cycle_count    = 0;
  int send_idle_pct  = 36;
  int recv_stall_pct = 80;
  int beats_sent     = 0;
  int settings_used  = 0;
  int hold_left      = 0;
  logic hold_flip    = 1'b0;
  logic hold_seen    = 1'b0;

  ultrasonic_echo_ranger u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_echo          (in_echo),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_trigger      (out_trigger),
    .out_led          (out_led),
    .out_measure_done (out_measure_done),
    .out_echo_us      (out_echo_us),
    .out_distance_cm  (out_distance_cm),
    .out_out_of_range (out_out_of_range)
  );

  ranger_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_echo          (in_echo),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_trigger      (out_trigger),
    .out_led          (out_led),
    .out_measure_done (out_measure_done),
    .out_echo_us      (out_echo_us),
    .out_distance_cm  (out_distance_cm),
    .out_out_of_range (out_out_of_range),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .measurements     (measurements)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic uer_pkg::uer_cfg_t make_cfg(int tpu, int tl, int th, int div,
                                                 int lim, int pause);
    uer_pkg::uer_cfg_t c;
    c.ticks_per_us    = uer_pkg::PreW'(tpu);
    c.trigger_low_us  = uer_pkg::TrigW'(tl);
    c.trigger_high_us = uer_pkg::TrigW'(th);
    c.cm_divisor_us   = uer_pkg::PreW'(div);
    c.range_limit_cm  = uer_pkg::CmW'(lim);
    c.pause_us        = uer_pkg::UsW'(pause);
    return c;
  endfunction

  task automatic write_cfg(uer_pkg::uer_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_addr  <= uer_pkg::REG_TICKS_PER_US;
    cfg_wdata <= uer_pkg::CfgDW'(c.ticks_per_us);
    @(posedge clk);
    cfg_addr  <= uer_pkg::REG_TRIGGER_LOW_US;
    cfg_wdata <= uer_pkg::CfgDW'(c.trigger_low_us);
    @(posedge clk);
    cfg_addr  <= uer_pkg::REG_TRIGGER_HIGH_US;
    cfg_wdata <= uer_pkg::CfgDW'(c.trigger_high_us);
    @(posedge clk);
    cfg_addr  <= uer_pkg::REG_CM_DIVISOR_US;
    cfg_wdata <= uer_pkg::CfgDW'(c.cm_divisor_us);
    @(posedge clk);
    cfg_addr  <= uer_pkg::REG_RANGE_LIMIT_CM;
    cfg_wdata <= uer_pkg::CfgDW'(c.range_limit_cm);
    @(posedge clk);
    cfg_addr  <= uer_pkg::REG_PAUSE_US;
    cfg_wdata <= uer_pkg::CfgDW'(c.pause_us);
    @(posedge clk);
    // unmapped index, must be ignored
    cfg_addr  <= REG_BEYOND + uer_pkg::CfgAW'($urandom_range(1));
    cfg_wdata <= uer_pkg::CfgDW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_echo(logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_echo  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic echo_pulse(int gap, int width);
    repeat (gap) send_echo(1'b0);
    repeat (width) send_echo(1'b1);
    send_echo(1'b0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  initial begin
    uer_pkg::uer_cfg_t c;
    int                est;
    int                span;
    int                eff_tpu;
    int                eff_div;
    int                start_beats;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short timed phases, echo during trigger ignored, edge cases
    write_cfg(make_cfg(1, 0, 1, 1, 3, 0));
    send_echo(1'b1);
    send_echo(1'b1);
    echo_pulse(1, 3);
    echo_pulse(3, 1);
    settle();
    write_cfg(make_cfg(0, 0, 0, 0, 2, 0));
    echo_pulse(3, 2);
    echo_pulse(3, 4);
    echo_pulse(3, 1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == RANDOM_PHASES / 3) begin
        send_idle_pct  = 80;
        recv_stall_pct = 36;
      end else if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      c = make_cfg($urandom_range(1, 3), $urandom_range(0, 4), $urandom_range(0, 3),
                   $urandom_range(1, 6), $urandom_range(0, 8), $urandom_range(0, 5));
      case (p)
        1: c.ticks_per_us = '0;
        2: c.cm_divisor_us = '0;
        3: c.range_limit_cm = '0;
        5: c.range_limit_cm = uer_pkg::CmMax;
        default: ;
      endcase
      write_cfg(c);
      if (p == 9) hold_flip <= ~hold_flip;
      eff_tpu = (c.ticks_per_us == '0) ? 1 : int'(c.ticks_per_us);
      eff_div = (c.cm_divisor_us == '0) ? 1 : int'(c.cm_divisor_us);
      est  = (int'(c.trigger_low_us) + int'(c.trigger_high_us) + int'(c.pause_us) + 3)
             * eff_tpu;
      span = eff_div * eff_tpu * (int'(c.range_limit_cm) + 2);
      if (span > 24) span = 24;
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 8)) send_echo(1'($urandom_range(1)));
        end else begin
          echo_pulse($urandom_range(0, est / 2 + 2), $urandom_range(1, span));
        end
      end
    end

    // full-scale trigger timing, with the sink held off while beats keep coming
    settle();
    write_cfg(make_cfg(1, 1023, 1023, 7, 20, 1));
    hold_flip <= ~hold_flip;
    repeat (60) send_echo(1'b0);

    // slowest prescaler, echo shorter than one microsecond
    settle();
    write_cfg(make_cfg(255, 0, 0, 1, 1, 0));
    repeat (2) send_echo(1'b0);
    echo_pulse(0, 20);
    repeat (2) send_echo(1'b0);

    // longest pause, widest divisor
    settle();
    write_cfg(make_cfg(1, 0, 0, 255, 1, 16777215));
    repeat (4) send_echo(1'b0);
    echo_pulse(0, 30);
    repeat (20) send_echo(1'b0);

    settle();
    $display("Run covered %0d echo beats under %0d register settings, %0d measurements.",
             beats_sent, settings_used, measurements);
    $display("Included zero and full-scale registers, slow prescaler and sink hold-offs.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
